### src/lfu_pkg.sv
package lfu_pkg;

  // Field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned StampW = 48;
  localparam int unsigned CapW   = 5;

  // Capacity register value after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Request codes carried in the input tuser
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  // One stored entry
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
    logic [StampW-1:0] touch;
  } lfu_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input word, clear the scan
    logic scan;    // read the entry at the scan index, advance
    logic commit;  // apply the update, load the result register
  } lfu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last entry
  } lfu_sts_t;

endpackage

### src/lfu_ctrl.sv
module lfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence one request: accept, scan every entry, drain the compare, commit
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Track the result word
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/lfu_datapath.sv
module lfu_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      in_command_i,
  input  logic [lfu_pkg::KeyW-1:0]  in_key_i,
  input  logic [lfu_pkg::DataW-1:0] in_value_i,
  output logic                      out_hit_o,
  output logic [lfu_pkg::DataW-1:0] out_read_value_o,
  output logic                      out_evicted_o,
  input  lfu_pkg::lfu_cmd_t         cmd_i,
  output lfu_pkg::lfu_sts_t         sts_o
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UseW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (UseW > lfu_pkg::CapW) ? UseW : lfu_pkg::CapW;

  // Entry memory and valid bits
  lfu_pkg::lfu_entry_t mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;

  logic [lfu_pkg::CapW-1:0]   capacity_q;
  logic [lfu_pkg::StampW-1:0] clock_q;

  // Captured request
  logic                      command_q;
  logic [lfu_pkg::KeyW-1:0]  key_q;
  logic [lfu_pkg::DataW-1:0] value_q;

  // Scan pipeline
  logic [IdxW-1:0]     scan_idx_q;
  logic                cmp_en_q;
  logic                rd_valid_q;
  logic [IdxW-1:0]     rd_idx_q;
  lfu_pkg::lfu_entry_t rd_entry_q;

  // Scan results
  logic                       found_q;
  logic [IdxW-1:0]            found_idx_q;
  logic [lfu_pkg::DataW-1:0]  found_data_q;
  logic [lfu_pkg::CountW-1:0] found_count_q;
  logic [UseW-1:0]            used_q;
  logic                       free_q;
  logic [IdxW-1:0]            free_idx_q;
  logic                       vic_q;
  logic [IdxW-1:0]            vic_idx_q;
  logic [lfu_pkg::CountW-1:0] vic_count_q;
  logic [lfu_pkg::StampW-1:0] vic_touch_q;

  // Result register
  logic                      hit_q;
  logic [lfu_pkg::DataW-1:0] read_value_q;
  logic                      evicted_q;

  // Update decision
  logic                       is_put;
  logic [CmpW-1:0]            cap_eff;
  logic                       need_evict;
  logic                       wr_en;
  logic [IdxW-1:0]            wr_idx;
  lfu_pkg::lfu_entry_t        wr_entry;
  logic                       set_valid;
  logic                       evict;
  logic [lfu_pkg::CountW-1:0] bumped_count;
  logic                       take_victim;

  assign sts_o.scan_last = (scan_idx_q == IdxW'(MAX_ENTRIES - 1));

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lfu_pkg::CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= in_command_i;
      key_q     <= in_key_i;
      value_q   <= in_value_i;
    end
  end

  // Advance the scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_en_q   <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IdxW'(1);
      end
    end
  end

  // Registered memory read at the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_entry_q <= mem[scan_idx_q];
      rd_valid_q <= valid_q[scan_idx_q];
      rd_idx_q   <= scan_idx_q;
    end
  end

  // Victim order: smaller count, then older touch
  assign take_victim = !vic_q || (rd_entry_q.count < vic_count_q) ||
                       ((rd_entry_q.count == vic_count_q) &&
                        (rd_entry_q.touch < vic_touch_q));

  // Fold each read entry into the match, fill, free and victim results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
      used_q  <= '0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
      used_q  <= '0;
    end else if (cmp_en_q) begin
      if (rd_valid_q) begin
        used_q <= used_q + UseW'(1);
        if (!found_q && (rd_entry_q.key == key_q)) begin
          found_q <= 1'b1;
        end
        if (take_victim) begin
          vic_q <= 1'b1;
        end
      end else if (!free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q) begin
      if (rd_valid_q) begin
        if (!found_q && (rd_entry_q.key == key_q)) begin
          found_idx_q   <= rd_idx_q;
          found_data_q  <= rd_entry_q.data;
          found_count_q <= rd_entry_q.count;
        end
        if (take_victim) begin
          vic_idx_q   <= rd_idx_q;
          vic_count_q <= rd_entry_q.count;
          vic_touch_q <= rd_entry_q.touch;
        end
      end else if (!free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // Decide the update from the scan results
  assign is_put       = (command_q == lfu_pkg::CmdPut);
  assign cap_eff      = (CmpW'(capacity_q) > CmpW'(MAX_ENTRIES)) ?
                        CmpW'(MAX_ENTRIES) : CmpW'(capacity_q);
  assign need_evict   = (CmpW'(used_q) >= cap_eff) || !free_q;
  assign bumped_count = (found_count_q == '1) ? found_count_q
                                              : found_count_q + lfu_pkg::CountW'(1);

  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = found_idx_q;
    set_valid      = 1'b0;
    evict          = 1'b0;
    wr_entry.key   = key_q;
    wr_entry.data  = found_data_q;
    wr_entry.count = bumped_count;
    wr_entry.touch = clock_q;
    if (!is_put) begin
      // get: bump a hit
      wr_en = found_q;
    end else if (capacity_q != '0) begin
      wr_entry.data = value_q;
      if (found_q) begin
        wr_en = 1'b1;
      end else begin
        // insert, displacing the victim when full
        wr_entry.count = lfu_pkg::CountW'(1);
        if (need_evict && vic_q) begin
          evict     = 1'b1;
          wr_idx    = vic_idx_q;
          wr_en     = 1'b1;
          set_valid = 1'b1;
        end else begin
          wr_idx    = free_idx_q;
          wr_en     = free_q;
          set_valid = free_q;
        end
      end
    end
  end

  // Write the entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Valid bits and access clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clock_q <= '0;
    end else if (cmd_i.commit) begin
      if (set_valid) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (wr_en) begin
        clock_q <= clock_q + lfu_pkg::StampW'(1);
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q        <= found_q;
      read_value_q <= (!is_put && found_q) ? found_data_q : '0;
      evicted_q    <= evict;
    end
  end

  assign out_hit_o        = hit_q;
  assign out_read_value_o = read_value_q;
  assign out_evicted_o    = evicted_q;

endmodule

### src/lfu_cache_store.sv
// Requests are taken one at a time: the next is accepted only after the last
//   commits, since each one scans the entry memory sequentially through its
//   single registered read port.
// A finished result waits in the output register while the next request scans;
//   that request then holds in its commit cycle until the register is taken.
// Reset: valid bits cleared, access clock zero, capacity 16, no result pending;
//   entry memory contents are not cleared.
module lfu_cache_store #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0] cfg_wdata_i,  // capacity_in_use
  // request stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [63:0]              s_axis_tdata,  // [31:0] key, [63:32] value
  input  logic [0:0]               s_axis_tuser,  // [0] command
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // [31:0] read_value
  output logic [1:0]               m_axis_tuser   // [0] hit, [1] evicted
);

  lfu_pkg::lfu_cmd_t cmd;
  lfu_pkg::lfu_sts_t sts;
  logic              hit;
  logic              evicted;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfu_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_command_i     (s_axis_tuser[0]),
    .in_key_i         (s_axis_tdata[31:0]),
    .in_value_i       (s_axis_tdata[63:32]),
    .out_hit_o        (hit),
    .out_read_value_o (m_axis_tdata),
    .out_evicted_o    (evicted),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  assign m_axis_tuser = {evicted, hit};

endmodule
